// ===== hw/rtl/sorted_window_trimmed_threshold_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the sorted window trimmed threshold core
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef SORTED_WINDOW_TRIMMED_THRESHOLD_CORE_MACROS_SVH
`define SORTED_WINDOW_TRIMMED_THRESHOLD_CORE_MACROS_SVH

// same-cycle implication
`define SWTT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SWTT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/swtt_pkg.sv =====
// ----------------------------------------------------------------------------
// swtt_pkg
// Shared types and constants of the sorted window trimmed threshold core.
// ----------------------------------------------------------------------------
package swtt_pkg;

	localparam int CAPACITY   = 1024;
	localparam int VALUE_BITS = 20;
	localparam int ADDR_W     = $clog2(CAPACITY);
	localparam int CNT_W      = $clog2(CAPACITY + 1);
	localparam int IN_W       = 21;
	localparam int MODE_W     = 2;
	localparam int K_W        = 4;
	localparam int SUM_W      = 30;
	localparam int SQ_W       = 50;
	localparam int SQ_LO_W    = 25;
	localparam int SQ_HI_W    = SQ_W - SQ_LO_W;
	localparam int MSQ_W      = CNT_W + SQ_W;
	localparam int LM_W       = IN_W - 1 + ADDR_W;
	localparam int VM_W       = IN_W + CNT_W + 1;
	localparam int L_W        = VM_W + 1;
	localparam int DVD_W      = MSQ_W;
	localparam int DVS_W      = 2 * (K_W + CNT_W);
	localparam int RECIP_W    = 16;
	localparam int RECIP_SH   = 19;
	localparam int PR_W       = CNT_W + 4 + RECIP_W;
	localparam int VAL_MAX    = 2 ** VALUE_BITS - 1;

	localparam logic [RECIP_W-1:0] RECIP_TEN = 16'd52429;
	localparam logic [K_W-1:0]     K_RESET   = 4'd5;
	localparam logic [MODE_W-1:0]  MODE_INSERT = 2'd0;

	typedef enum logic [2:0] {
		RES_OK,
		RES_NOT_FOUND,
		RES_FULL,
		RES_MASKED,
		RES_FEW
	} res_code_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INS_SCAN,
		ST_INS_LAST,
		ST_DEL_SCAN,
		ST_QRY_SCAN,
		ST_MUL1,
		ST_MUL2,
		ST_MUL3,
		ST_MUL4,
		ST_DIV1_GO,
		ST_DIV1_WAIT,
		ST_DIV2_GO,
		ST_DIV2_WAIT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic      accept;
		logic      ins_scan;
		logic      ins_last;
		logic      del_scan;
		logic      qry_scan;
		logic      mul1;
		logic      mul2;
		logic      mul3;
		logic      mul4;
		logic      div1_go;
		logic      div2_go;
		logic      div1_cap;
		logic      div2_cap;
		logic      spot_one;
		logic      res_set;
		res_code_t res_code;
		logic      out_load;
	} cmd_t;

	typedef struct packed {
		logic in_query;
		logic in_masked;
		logic in_insert;
		logic full;
		logic empty;
		logic ins_stop;
		logic del_end;
		logic del_found;
		logic qry_few;
		logic qry_done;
		logic div_busy;
		logic div_done;
		logic l_pos;
		logic cc_zero;
		logic out_busy;
	} sts_t;

endpackage

// ===== hw/rtl/swtt_div.sv =====
// ----------------------------------------------------------------------------
// swtt_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module swtt_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [swtt_pkg::DVD_W-1:0] dividend,
	input  logic [swtt_pkg::DVS_W-1:0] divisor,
	output logic                       busy,
	output logic                       done,
	output logic [swtt_pkg::DVD_W-1:0] quotient
);

	localparam int CW = $clog2(swtt_pkg::DVD_W + 1);

	logic [CW-1:0]                cnt_q;
	logic                         busy_q;
	logic                         done_q;
	logic [swtt_pkg::DVD_W-1:0]   quo_q;
	logic [swtt_pkg::DVS_W-1:0]   rem_q;
	logic [swtt_pkg::DVS_W-1:0]   dvs_q;
	logic [swtt_pkg::DVS_W:0]     trial;
	logic [swtt_pkg::DVS_W:0]     diff;
	logic                         qbit;

	assign trial = {rem_q, quo_q[swtt_pkg::DVD_W-1]};
	assign qbit  = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= CW'(swtt_pkg::DVD_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[swtt_pkg::DVD_W-2:0], qbit};
			rem_q <= qbit ? diff[swtt_pkg::DVS_W-1:0] : trial[swtt_pkg::DVS_W-1:0];
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== hw/rtl/swtt_datapath.sv =====
// ----------------------------------------------------------------------------
// swtt_datapath
// Sorted value store, scan pipeline, trimmed sums and threshold arithmetic.
// ----------------------------------------------------------------------------
module swtt_datapath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  swtt_pkg::cmd_t                  cmd,
	output swtt_pkg::sts_t                  sts,
	input  logic [swtt_pkg::MODE_W-1:0]     mode,
	input  logic signed [swtt_pkg::IN_W-1:0] value,
	input  logic                            cfg_we,
	input  logic [swtt_pkg::K_W-1:0]        cfg_wdata,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [2:0]                      status,
	output logic [swtt_pkg::ADDR_W-1:0]     position,
	output logic [swtt_pkg::CNT_W-1:0]      count,
	output logic [swtt_pkg::SUM_W-1:0]      trimmed_sum,
	output logic [swtt_pkg::SQ_W-1:0]       trimmed_square_sum,
	output logic                            is_spot
);

	localparam int AW = swtt_pkg::ADDR_W;
	localparam int CW = swtt_pkg::CNT_W;
	localparam int VB = swtt_pkg::VALUE_BITS;

	// control registers
	logic [CW-1:0]            n_q;
	logic [swtt_pkg::K_W-1:0] k_q;
	logic [CW-1:0]            idx_q;
	logic                     rv_s1;
	logic                     v_s2;
	logic                     found_q;
	logic                     out_valid_q;

	// payload registers
	logic [VB-1:0]                 mem [swtt_pkg::CAPACITY];
	logic [VB-1:0]                 rd_data_s1;
	logic [AW-1:0]                 ra_s1;
	logic [VB-1:0]                 x_s2;
	logic [2*VB-1:0]               sqr_s2;
	logic [VB-1:0]                 v_q;
	logic signed [swtt_pkg::IN_W-1:0] val_q;
	logic [CW-1:0]                 hi_q;
	logic [CW-1:0]                 m_q;
	logic [AW-1:0]                 pos_q;
	logic [swtt_pkg::SUM_W-1:0]    s_q;
	logic [swtt_pkg::SQ_W-1:0]     sq_q;
	logic [CW+swtt_pkg::SQ_LO_W-1:0] pa_q;
	logic [CW+swtt_pkg::SQ_HI_W-1:0] pb_q;
	logic [2*swtt_pkg::SUM_W-1:0]  s2_q;
	logic [2*CW-1:0]               den_q;
	logic signed [swtt_pkg::VM_W-1:0] vm_q;
	logic signed [swtt_pkg::L_W-1:0]  l_q;
	logic [swtt_pkg::K_W+CW-1:0]   c_q;
	logic [swtt_pkg::DVS_W-1:0]    cc_q;
	logic [swtt_pkg::MSQ_W-1:0]    msq_q;
	logic [2*swtt_pkg::LM_W-1:0]   ll_q;
	logic [swtt_pkg::MSQ_W-1:0]    num_q;
	logic [swtt_pkg::DVD_W-1:0]    d_q;
	logic                          spot_q;
	swtt_pkg::res_code_t           res_q;

	logic [2:0]                    status_q;
	logic [AW-1:0]                 position_q;
	logic [CW-1:0]                 count_q;
	logic [swtt_pkg::SUM_W-1:0]    tsum_q;
	logic [swtt_pkg::SQ_W-1:0]     tsq_q;
	logic                          is_spot_q;

	// combinational
	logic [VB-1:0]               value_sat;
	logic [CW+3:0]               n9;
	logic [swtt_pkg::PR_W-1:0]   prod_lo;
	logic [swtt_pkg::PR_W-1:0]   prod_hi;
	logic [CW-1:0]               lo_c;
	logic [CW-1:0]               hi_c;
	logic                        issue;
	logic                        ins_cmp;
	logic                        del_cmp;
	logic                        gt;
	logic                        eq;
	logic                        wr_en;
	logic [AW-1:0]               wr_addr;
	logic [VB-1:0]               wr_data;
	logic                        div_start;
	logic [swtt_pkg::DVD_W-1:0]  div_dvd;
	logic [swtt_pkg::DVS_W-1:0]  div_dvs;
	logic                        div_busy;
	logic                        div_done;
	logic [swtt_pkg::DVD_W-1:0]  div_quo;

	always_comb begin
		if (value[swtt_pkg::IN_W-1]) begin
			value_sat = '0;
		end else if (value[swtt_pkg::IN_W-2:0] > (swtt_pkg::IN_W-1)'(swtt_pkg::VAL_MAX)) begin
			value_sat = VB'(swtt_pkg::VAL_MAX);
		end else begin
			value_sat = value[VB-1:0];
		end
	end

	// floor(x/10) by reciprocal multiply
	assign n9      = {n_q, 3'b000} + (CW+4)'(n_q);
	assign prod_lo = swtt_pkg::PR_W'(n_q) * swtt_pkg::RECIP_TEN;
	assign prod_hi = swtt_pkg::PR_W'(n9) * swtt_pkg::RECIP_TEN;
	assign lo_c    = prod_lo[swtt_pkg::RECIP_SH +: CW];
	assign hi_c    = prod_hi[swtt_pkg::RECIP_SH +: CW];

	assign ins_cmp = cmd.ins_scan && rv_s1;
	assign del_cmp = cmd.del_scan && rv_s1;
	assign gt      = rd_data_s1 > v_q;
	assign eq      = rd_data_s1 == v_q;

	always_comb begin
		issue = 1'b0;
		if (cmd.ins_scan) begin
			issue = idx_q < CW'(swtt_pkg::CAPACITY);
		end else if (cmd.del_scan) begin
			issue = idx_q < n_q;
		end else if (cmd.qry_scan) begin
			issue = (m_q >= CW'(2)) && (idx_q < hi_q);
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = ra_s1 + 1'b1;
		wr_data = rd_data_s1;
		if (ins_cmp && gt) begin
			wr_en = 1'b1;
		end else if (del_cmp && found_q) begin
			wr_en   = 1'b1;
			wr_addr = ra_s1 - 1'b1;
		end else if (cmd.ins_last) begin
			wr_en   = 1'b1;
			wr_addr = pos_q;
			wr_data = v_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_s1 <= mem[idx_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q         <= '0;
			k_q         <= swtt_pkg::K_RESET;
			idx_q       <= '0;
			rv_s1       <= 1'b0;
			v_s2        <= 1'b0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				k_q <= cfg_wdata;
			end
			rv_s1 <= issue;
			v_s2  <= rv_s1 && cmd.qry_scan;
			if (cmd.accept) begin
				found_q <= 1'b0;
				if (mode[1]) begin
					idx_q <= lo_c;
				end else if (mode == swtt_pkg::MODE_INSERT) begin
					idx_q <= n_q - 1'b1;
				end else begin
					idx_q <= '0;
				end
			end else if (issue) begin
				idx_q <= cmd.ins_scan ? idx_q - 1'b1 : idx_q + 1'b1;
			end
			if (del_cmp && !found_q && eq) begin
				found_q <= 1'b1;
			end
			if (cmd.ins_last) begin
				n_q <= n_q + 1'b1;
			end else if (sts.del_end && sts.del_found) begin
				n_q <= n_q - 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		ra_s1  <= idx_q[AW-1:0];
		x_s2   <= rd_data_s1;
		sqr_s2 <= rd_data_s1 * rd_data_s1;
		if (cmd.accept) begin
			v_q    <= value_sat;
			val_q  <= value;
			hi_q   <= hi_c;
			m_q    <= hi_c - lo_c;
			pos_q  <= '0;
			s_q    <= '0;
			sq_q   <= '0;
			spot_q <= 1'b0;
		end else begin
			if (ins_cmp && (!gt || ra_s1 == '0)) begin
				pos_q <= gt ? '0 : ra_s1 + 1'b1;
			end
			if (del_cmp && !found_q && eq) begin
				pos_q <= ra_s1;
			end
			if (v_s2) begin
				s_q  <= s_q + swtt_pkg::SUM_W'(x_s2);
				sq_q <= sq_q + swtt_pkg::SQ_W'(sqr_s2);
			end
			if (cmd.spot_one) begin
				spot_q <= 1'b1;
			end else if (cmd.div2_cap) begin
				spot_q <= div_quo >= d_q;
			end
		end
		if (cmd.res_set) begin
			res_q <= cmd.res_code;
		end
		if (cmd.mul1) begin
			pa_q  <= m_q * sq_q[swtt_pkg::SQ_LO_W-1:0];
			s2_q  <= s_q * s_q;
			den_q <= m_q * (m_q - 1'b1);
			vm_q  <= val_q * $signed({1'b0, m_q});
			c_q   <= k_q * m_q;
		end
		if (cmd.mul2) begin
			pb_q <= m_q * sq_q[swtt_pkg::SQ_W-1:swtt_pkg::SQ_LO_W];
			l_q  <= vm_q - $signed({1'b0, s_q});
			cc_q <= c_q * c_q;
		end
		if (cmd.mul3) begin
			msq_q <= swtt_pkg::MSQ_W'(pa_q)
				+ (swtt_pkg::MSQ_W'(pb_q) << swtt_pkg::SQ_LO_W);
			ll_q  <= l_q[swtt_pkg::LM_W-1:0] * l_q[swtt_pkg::LM_W-1:0];
		end
		if (cmd.mul4) begin
			if (msq_q >= swtt_pkg::MSQ_W'(s2_q)) begin
				num_q <= msq_q - swtt_pkg::MSQ_W'(s2_q);
			end else begin
				num_q <= swtt_pkg::MSQ_W'(s2_q) - msq_q;
			end
		end
		if (cmd.div1_cap) begin
			d_q <= div_quo;
		end
		if (cmd.out_load) begin
			status_q   <= res_q;
			position_q <= pos_q;
			count_q    <= n_q;
			tsum_q     <= s_q;
			tsq_q      <= sq_q;
			is_spot_q  <= spot_q;
		end
	end

	assign div_start = cmd.div1_go || cmd.div2_go;
	assign div_dvd   = cmd.div2_go ? swtt_pkg::DVD_W'(ll_q - 1'b1) : num_q;
	assign div_dvs   = cmd.div2_go ? cc_q : swtt_pkg::DVS_W'(den_q);

	swtt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_comb begin
		sts.in_query  = mode[1];
		sts.in_masked = value[swtt_pkg::IN_W-1];
		sts.in_insert = mode == swtt_pkg::MODE_INSERT;
		sts.full      = n_q >= CW'(swtt_pkg::CAPACITY);
		sts.empty     = n_q == '0;
		sts.ins_stop  = ins_cmp && (!gt || ra_s1 == '0);
		sts.del_end   = del_cmp && ({1'b0, ra_s1} == n_q - 1'b1);
		sts.del_found = found_q || eq;
		sts.qry_few   = m_q < CW'(2);
		sts.qry_done  = (idx_q >= hi_q) && !rv_s1 && !v_s2;
		sts.div_busy  = div_busy;
		sts.div_done  = div_done;
		sts.l_pos     = !l_q[swtt_pkg::L_W-1] && (l_q != '0);
		sts.cc_zero   = cc_q == '0;
		sts.out_busy  = out_valid_q && out_stall;
	end

	assign out_valid          = out_valid_q;
	assign status             = status_q;
	assign position           = position_q;
	assign count              = count_q;
	assign trimmed_sum        = tsum_q;
	assign trimmed_square_sum = tsq_q;
	assign is_spot            = is_spot_q;

endmodule

// ===== hw/rtl/swtt_ctrl.sv =====
// ----------------------------------------------------------------------------
// swtt_ctrl
// Sequencer for insert, delete and query operations.
// ----------------------------------------------------------------------------
module swtt_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  swtt_pkg::sts_t sts,
	output swtt_pkg::cmd_t cmd
);

	swtt_pkg::state_t state_q;
	swtt_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= swtt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			swtt_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (sts.in_query) begin
						state_d = swtt_pkg::ST_QRY_SCAN;
					end else if (sts.in_masked) begin
						state_d = swtt_pkg::ST_DONE;
					end else if (sts.in_insert) begin
						if (sts.full) begin
							state_d = swtt_pkg::ST_DONE;
						end else if (sts.empty) begin
							state_d = swtt_pkg::ST_INS_LAST;
						end else begin
							state_d = swtt_pkg::ST_INS_SCAN;
						end
					end else if (sts.empty) begin
						state_d = swtt_pkg::ST_DONE;
					end else begin
						state_d = swtt_pkg::ST_DEL_SCAN;
					end
				end
			end
			swtt_pkg::ST_INS_SCAN: begin
				if (sts.ins_stop) begin
					state_d = swtt_pkg::ST_INS_LAST;
				end
			end
			swtt_pkg::ST_INS_LAST: state_d = swtt_pkg::ST_DONE;
			swtt_pkg::ST_DEL_SCAN: begin
				if (sts.del_end) begin
					state_d = swtt_pkg::ST_DONE;
				end
			end
			swtt_pkg::ST_QRY_SCAN: begin
				if (sts.qry_few) begin
					state_d = swtt_pkg::ST_DONE;
				end else if (sts.qry_done) begin
					state_d = swtt_pkg::ST_MUL1;
				end
			end
			swtt_pkg::ST_MUL1:    state_d = swtt_pkg::ST_MUL2;
			swtt_pkg::ST_MUL2:    state_d = swtt_pkg::ST_MUL3;
			swtt_pkg::ST_MUL3:    state_d = swtt_pkg::ST_MUL4;
			swtt_pkg::ST_MUL4:    state_d = swtt_pkg::ST_DIV1_GO;
			swtt_pkg::ST_DIV1_GO: state_d = swtt_pkg::ST_DIV1_WAIT;
			swtt_pkg::ST_DIV1_WAIT: begin
				if (sts.div_done) begin
					if (sts.l_pos && !sts.cc_zero) begin
						state_d = swtt_pkg::ST_DIV2_GO;
					end else begin
						state_d = swtt_pkg::ST_DONE;
					end
				end
			end
			swtt_pkg::ST_DIV2_GO: state_d = swtt_pkg::ST_DIV2_WAIT;
			swtt_pkg::ST_DIV2_WAIT: begin
				if (sts.div_done) begin
					state_d = swtt_pkg::ST_DONE;
				end
			end
			swtt_pkg::ST_DONE: begin
				if (!sts.out_busy) begin
					state_d = swtt_pkg::ST_IDLE;
				end
			end
			default: state_d = swtt_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.res_code = swtt_pkg::RES_OK;
		in_stall     = state_q != swtt_pkg::ST_IDLE;
		case (state_q)
			swtt_pkg::ST_IDLE: begin
				cmd.accept = in_valid;
				if (in_valid && !sts.in_query) begin
					if (sts.in_masked) begin
						cmd.res_set  = 1'b1;
						cmd.res_code = swtt_pkg::RES_MASKED;
					end else if (sts.in_insert && sts.full) begin
						cmd.res_set  = 1'b1;
						cmd.res_code = swtt_pkg::RES_FULL;
					end else if (!sts.in_insert && sts.empty) begin
						cmd.res_set  = 1'b1;
						cmd.res_code = swtt_pkg::RES_NOT_FOUND;
					end
				end
			end
			swtt_pkg::ST_INS_SCAN: cmd.ins_scan = 1'b1;
			swtt_pkg::ST_INS_LAST: begin
				cmd.ins_last = 1'b1;
				cmd.res_set  = 1'b1;
			end
			swtt_pkg::ST_DEL_SCAN: begin
				cmd.del_scan = 1'b1;
				if (sts.del_end) begin
					cmd.res_set  = 1'b1;
					cmd.res_code = sts.del_found ? swtt_pkg::RES_OK : swtt_pkg::RES_NOT_FOUND;
				end
			end
			swtt_pkg::ST_QRY_SCAN: begin
				cmd.qry_scan = 1'b1;
				if (sts.qry_few) begin
					cmd.res_set  = 1'b1;
					cmd.res_code = swtt_pkg::RES_FEW;
				end
			end
			swtt_pkg::ST_MUL1:    cmd.mul1 = 1'b1;
			swtt_pkg::ST_MUL2:    cmd.mul2 = 1'b1;
			swtt_pkg::ST_MUL3:    cmd.mul3 = 1'b1;
			swtt_pkg::ST_MUL4:    cmd.mul4 = 1'b1;
			swtt_pkg::ST_DIV1_GO: cmd.div1_go = 1'b1;
			swtt_pkg::ST_DIV1_WAIT: begin
				if (sts.div_done) begin
					cmd.div1_cap = 1'b1;
					cmd.res_set  = 1'b1;
					cmd.spot_one = sts.l_pos && sts.cc_zero;
				end
			end
			swtt_pkg::ST_DIV2_GO: cmd.div2_go = 1'b1;
			swtt_pkg::ST_DIV2_WAIT: cmd.div2_cap = sts.div_done;
			swtt_pkg::ST_DONE:    cmd.out_load = !sts.out_busy;
			default: ;
		endcase
	end

endmodule

// ===== hw/rtl/sorted_window_trimmed_threshold_core.sv =====
// ----------------------------------------------------------------------------
// sorted_window_trimmed_threshold_core
// Sorted pixel window with trimmed mean / sigma spot test.
// ----------------------------------------------------------------------------
// One item is in work at a time. An insert walks the value memory from the top
// entry down and a delete walks it from the bottom up, one entry per cycle,
// shifting as they go; the memory has one read port and one write port. A
// query makes one memory read per trimmed rank and lets the read pipeline
// drain, then takes four multiply steps and one or two 61-bit passes of the
// bit-serial divider. A finished result waits in the output register while
// the next item is taken.
// ----------------------------------------------------------------------------
`include "sorted_window_trimmed_threshold_core_macros.svh"

module sorted_window_trimmed_threshold_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [swtt_pkg::MODE_W-1:0]      mode,
	input  logic signed [swtt_pkg::IN_W-1:0] value,
	input  logic                             cfg_we,
	input  logic [swtt_pkg::K_W-1:0]         cfg_wdata,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [2:0]                       status,
	output logic [swtt_pkg::ADDR_W-1:0]      position,
	output logic [swtt_pkg::CNT_W-1:0]       count,
	output logic [swtt_pkg::SUM_W-1:0]       trimmed_sum,
	output logic [swtt_pkg::SQ_W-1:0]        trimmed_square_sum,
	output logic                             is_spot
);

	swtt_pkg::cmd_t cmd;
	swtt_pkg::sts_t sts;

	swtt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	swtt_datapath u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.sts                (sts),
		.mode               (mode),
		.value              (value),
		.cfg_we             (cfg_we),
		.cfg_wdata          (cfg_wdata),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.status             (status),
		.position           (position),
		.count              (count),
		.trimmed_sum        (trimmed_sum),
		.trimmed_square_sum (trimmed_square_sum),
		.is_spot            (is_spot)
	);

	`SWTT_ASSERT_NXT(a_accept_busy, in_valid && !in_stall, in_stall, "accepted item did not busy the block")
	`SWTT_ASSERT_IMP(a_load_free, cmd.out_load, !(out_valid && out_stall), "result loaded over a held item")
	`SWTT_ASSERT_IMP(a_div_idle, cmd.div1_go || cmd.div2_go, !sts.div_busy, "divider restarted while busy")
	`SWTT_ASSERT_IMP(a_count_cap, out_valid, count <= swtt_pkg::CAPACITY, "count above capacity")

endmodule

// ===== sim/sorted_window_trimmed_threshold_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_window_trimmed_threshold_core_test
// Self-checking bench: table-driven directed items, then random windows of
// insert/delete/query traffic against a behavioral copy of the sorted store,
// with random idle bursts on both sides and several sigma multiplier
// settings.
// ----------------------------------------------------------------------------
module sorted_window_trimmed_threshold_core_test;

	localparam logic [swtt_pkg::MODE_W-1:0] MODE_DELETE = 2'd1;
	localparam logic [swtt_pkg::MODE_W-1:0] MODE_QUERY  = 2'd2;
	localparam logic [swtt_pkg::MODE_W-1:0] MODE_QUERY3 = 2'd3;
	localparam int STALL_LIMIT = 20000;
	localparam int RANDOM_ITEMS = 540;

	typedef struct {
		logic [2:0]                  status;
		logic [swtt_pkg::ADDR_W-1:0] position;
		logic [swtt_pkg::CNT_W-1:0]  count;
		logic [swtt_pkg::SUM_W-1:0]  tsum;
		logic [swtt_pkg::SQ_W-1:0]   tsq;
		logic                        spot;
	} window_result_t;

	typedef struct {
		logic [swtt_pkg::MODE_W-1:0] mode;
		int                          value;
		bit                          typed;
		swtt_pkg::res_code_t         status;
		int                          position;
		int                          count;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [swtt_pkg::MODE_W-1:0] mode = '0;
	logic signed [swtt_pkg::IN_W-1:0] value = '0;
	logic cfg_we = 1'b0;
	logic [swtt_pkg::K_W-1:0] cfg_wdata = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [2:0] status;
	logic [swtt_pkg::ADDR_W-1:0] position;
	logic [swtt_pkg::CNT_W-1:0] count;
	logic [swtt_pkg::SUM_W-1:0] trimmed_sum;
	logic [swtt_pkg::SQ_W-1:0] trimmed_square_sum;
	logic is_spot;

	sorted_window_trimmed_threshold_core uut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	logic [swtt_pkg::VALUE_BITS-1:0] window_vals [swtt_pkg::CAPACITY];
	int unsigned held;
	logic [swtt_pkg::K_W-1:0] sigma_k = swtt_pkg::K_RESET;
	window_result_t pending_results [$];
	int errors = 0, items_sent = 0, results_seen = 0, spots_seen = 0, full_hits = 0;
	bit quiet = 1'b0;
	int stall_burst = 0;
	int idle_cycles = 0;

	function automatic window_result_t window_step(logic [swtt_pkg::MODE_W-1:0] md,
			logic signed [swtt_pkg::IN_W-1:0] v);
		window_result_t r;
		longint sv;
		longint unsigned lo, hi, m, s, sq, num, d, c, l, x;
		longint lsig;
		int unsigned p;
		r = '{swtt_pkg::RES_OK, '0, '0, '0, '0, 1'b0};
		sv = longint'(v);
		if (md[1]) begin
			lo = held / 10;
			hi = (9 * held) / 10;
			m = hi - lo;
			if (m < 2) begin
				r.status = swtt_pkg::RES_FEW;
			end else begin
				s = 0;
				sq = 0;
				for (longint unsigned i = lo; i < hi; i++) begin
					x = window_vals[i];
					s += x;
					sq += x * x;
				end
				num = m * sq;
				num = (num >= s * s) ? num - s * s : s * s - num;
				d = num / (m * (m - 1));
				lsig = sv * longint'(m) - longint'(s);
				if (lsig > 0) begin
					l = lsig;
					c = sigma_k * m;
					if (c == 0 || (l * l - 1) / (c * c) >= d)
						r.spot = 1'b1;
				end
				r.tsum = swtt_pkg::SUM_W'(s);
				r.tsq = swtt_pkg::SQ_W'(sq);
			end
		end else if (sv < 0) begin
			r.status = swtt_pkg::RES_MASKED;
		end else begin
			if (sv > swtt_pkg::VAL_MAX)
				sv = swtt_pkg::VAL_MAX;
			if (md == swtt_pkg::MODE_INSERT) begin
				if (held >= swtt_pkg::CAPACITY) begin
					r.status = swtt_pkg::RES_FULL;
				end else begin
					for (p = 0; p < held; p++)
						if (sv < window_vals[p])
							break;
					for (int unsigned i = held; i > p; i--)
						window_vals[i] = window_vals[i-1];
					window_vals[p] = swtt_pkg::VALUE_BITS'(sv);
					held++;
					r.position = swtt_pkg::ADDR_W'(p);
				end
			end else begin
				for (p = 0; p < held; p++)
					if (window_vals[p] == sv)
						break;
				if (p == held) begin
					r.status = swtt_pkg::RES_NOT_FOUND;
				end else begin
					for (int unsigned i = p; i + 1 < held; i++)
						window_vals[i] = window_vals[i+1];
					held--;
					r.position = swtt_pkg::ADDR_W'(p);
				end
			end
		end
		r.count = swtt_pkg::CNT_W'(held);
		return r;
	endfunction

	task automatic idle_input(int n);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// returns the predicted result, computed on acceptance; the caller queues it
	task automatic send_item(logic [swtt_pkg::MODE_W-1:0] md, int v,
			output window_result_t r);
		in_valid <= 1'b1;
		mode <= md;
		value <= swtt_pkg::IN_W'(v);
		do @(posedge clk); while (in_stall);
		r = window_step(md, swtt_pkg::IN_W'(v));
		items_sent++;
		if (r.status == swtt_pkg::RES_FULL)
			full_hits++;
	endtask

	task automatic push_item(logic [swtt_pkg::MODE_W-1:0] md, int v);
		window_result_t r;
		send_item(md, v, r);
		pending_results.push_back(r);
		if (!quiet && $urandom_range(0, 5) == 0)
			idle_input($urandom_range(1, 6));
	endtask

	task automatic drain_results();
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_sigma(logic [swtt_pkg::K_W-1:0] k);
		in_valid <= 1'b0;
		drain_results();
		repeat (8) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= k;
		@(posedge clk);
		cfg_we <= 1'b0;
		sigma_k = k;
		@(posedge clk);
	endtask

	task automatic check_field(string name, longint unsigned e, longint unsigned a);
		if (e != a) begin
			errors++;
			$display("%0t %s mismatch: expected %0d actual %0d", $time, name, e, a);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t unexpected result: status %0d count %0d", $time, status, count);
			end else begin
				window_result_t e;
				e = pending_results.pop_front();
				check_field("status", e.status, status);
				check_field("position", e.position, position);
				check_field("count", e.count, count);
				check_field("trimmed_sum", e.tsum, trimmed_sum);
				check_field("trimmed_square_sum", e.tsq, trimmed_square_sum);
				check_field("is_spot", e.spot, is_spot);
				if (is_spot)
					spots_seen++;
			end
		end
		if (stall_burst > 0) begin
			stall_burst <= stall_burst - 1;
		end else if (!quiet && arst_n && $urandom_range(0, 7) == 0) begin
			stall_burst <= $urandom_range(1, 6);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t watchdog: no progress", $time);
			$display("[sorted_window_trimmed_threshold_core] ERROR");
			$finish;
		end
	end

	stim_row_t directed [] = '{
		'{MODE_QUERY,            0,        1, swtt_pkg::RES_FEW,       0, 0},
		'{MODE_DELETE,           7,        1, swtt_pkg::RES_NOT_FOUND, 0, 0},
		'{swtt_pkg::MODE_INSERT, -1,       1, swtt_pkg::RES_MASKED,    0, 0},
		'{MODE_DELETE,           -1048576, 1, swtt_pkg::RES_MASKED,    0, 0},
		'{swtt_pkg::MODE_INSERT, 0,        1, swtt_pkg::RES_OK,        0, 1},
		'{swtt_pkg::MODE_INSERT, 1048575,  1, swtt_pkg::RES_OK,        1, 2},
		'{MODE_QUERY3,           1048575,  1, swtt_pkg::RES_FEW,       0, 2},
		'{swtt_pkg::MODE_INSERT, 1048575,  1, swtt_pkg::RES_OK,        2, 3},
		'{swtt_pkg::MODE_INSERT, 0,        1, swtt_pkg::RES_OK,        1, 4},
		'{MODE_DELETE,           1048575,  1, swtt_pkg::RES_OK,        2, 3},
		'{swtt_pkg::MODE_INSERT, 500,      0, swtt_pkg::RES_OK,        0, 0},
		'{swtt_pkg::MODE_INSERT, 520,      0, swtt_pkg::RES_OK,        0, 0},
		'{swtt_pkg::MODE_INSERT, 480,      0, swtt_pkg::RES_OK,        0, 0},
		'{swtt_pkg::MODE_INSERT, 510,      0, swtt_pkg::RES_OK,        0, 0},
		'{swtt_pkg::MODE_INSERT, 490,      0, swtt_pkg::RES_OK,        0, 0},
		'{swtt_pkg::MODE_INSERT, 505,      0, swtt_pkg::RES_OK,        0, 0},
		'{swtt_pkg::MODE_INSERT, 495,      0, swtt_pkg::RES_OK,        0, 0},
		'{swtt_pkg::MODE_INSERT, 515,      0, swtt_pkg::RES_OK,        0, 0},
		'{swtt_pkg::MODE_INSERT, 485,      0, swtt_pkg::RES_OK,        0, 0},
		'{MODE_QUERY,            2000,     0, swtt_pkg::RES_OK,        0, 0},
		'{MODE_QUERY,            -1,       0, swtt_pkg::RES_OK,        0, 0},
		'{MODE_QUERY,            -1048576, 0, swtt_pkg::RES_OK,        0, 0},
		'{MODE_QUERY,            1048575,  0, swtt_pkg::RES_OK,        0, 0},
		'{MODE_QUERY3,           500,      0, swtt_pkg::RES_OK,        0, 0},
		'{MODE_DELETE,           12345,    0, swtt_pkg::RES_OK,        0, 0}
	};

	function automatic int pixel_value(int base);
		case ($urandom_range(0, 7))
			0: return $urandom_range(0, 1048575);
			1: return base + $urandom_range(0, 4000);
			default: return base + $urandom_range(0, 64);
		endcase
	endfunction

	initial begin
		window_result_t r;
		int base, target, op, v;
		logic [swtt_pkg::K_W-1:0] sigma_plan [] = '{4'd0, 4'd15, 4'd1, 4'd5, 4'd15, 4'd0};
		for (int i = 0; i < swtt_pkg::CAPACITY; i++)
			window_vals[i] = '0;
		held = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			send_item(directed[i].mode, directed[i].value, r);
			if (directed[i].typed)
				r = '{directed[i].status, swtt_pkg::ADDR_W'(directed[i].position),
					swtt_pkg::CNT_W'(directed[i].count), '0, '0, 1'b0};
			pending_results.push_back(r);
			if ($urandom_range(0, 3) == 0)
				idle_input($urandom_range(1, 6));
		end

		for (int ph = 0; ph < sigma_plan.size(); ph++) begin
			write_sigma(ph == 3 ? swtt_pkg::K_W'($urandom_range(0, 15)) : sigma_plan[ph]);
			quiet = (ph == sigma_plan.size() - 1);
			base = $urandom_range(0, 1040000);
			target = (ph == 2) ? 200 : $urandom_range(5, 60);
			for (int n = 0; n < RANDOM_ITEMS / sigma_plan.size(); n++) begin
				op = $urandom_range(0, 99);
				if (held >= target && op < 40)
					op = 45;
				if (op < 40) begin
					push_item(swtt_pkg::MODE_INSERT, pixel_value(base));
				end else if (op < 60 && held > 0) begin
					push_item(MODE_DELETE, int'(window_vals[$urandom_range(0, held - 1)]));
				end else if (op < 65) begin
					push_item(MODE_DELETE, pixel_value(base));
				end else if (op < 88) begin
					v = ($urandom_range(0, 9) == 0) ? -$urandom_range(1, 1048576)
						: pixel_value(base);
					push_item(MODE_QUERY, v);
				end else if (op < 95) begin
					v = ($urandom_range(0, 1)) ? -1 : -$urandom_range(1, 1048576);
					push_item(swtt_pkg::MODE_W'(swtt_pkg::MODE_INSERT + $urandom_range(0, 1)),
						v);
				end else begin
					push_item(MODE_QUERY3, pixel_value(base));
				end
			end
		end
		in_valid <= 1'b0;
		drain_results();
		repeat (200) @(posedge clk);

		$display("items %0d, results %0d, spots flagged %0d, full-store rejects %0d",
			items_sent, results_seen, spots_seen, full_hits);
		$display("sigma settings 0, 1, 5, 15 and random; masked, absent and few-value cases");
		if (errors == 0)
			$display("[sorted_window_trimmed_threshold_core] OK");
		else
			$display("[sorted_window_trimmed_threshold_core] ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/swtt_pkg.sv
hw/rtl/swtt_div.sv
hw/rtl/swtt_datapath.sv
hw/rtl/swtt_ctrl.sv
hw/rtl/sorted_window_trimmed_threshold_core.sv
sim/sorted_window_trimmed_threshold_core_test.sv
